@@ src/liq_pkg.sv @@
// shared types and constants of the labeled interval overlap query
package liq_pkg;
	localparam int unsigned EntriesDefault = 4096;
	localparam int unsigned LabelsDefault = 16;
	localparam int unsigned MaxCompDefault = 16;
	localparam int unsigned LinearLimitDefault = 15;
	localparam int unsigned MaxHitsDefault = 64;

	typedef enum logic [1:0] {
		KIND_ENTRY = 2'd0,
		KIND_COMP  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_FILTER_ENABLE = 2'd0,
		REG_MIN_LENGTH    = 2'd1,
		REG_MAX_LENGTH    = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] addr;
		logic [3:0]  label;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic [31:0] max_end;
		logic [31:0] item_id;
		logic [11:0] comp_first;
		logic [12:0] comp_len;
		logic [4:0]  comp_count;
	} in_item_t;

	typedef struct packed {
		logic [31:0] query_tag;
		logic [31:0] hit_id;
		logic [31:0] hit_start;
		logic [31:0] hit_end;
		logic        hit_valid;
		logic        truncated;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_item_t;
endpackage

@@ src/liq_if.sv @@
// valid/ready channel interface carrying one payload
interface liq_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/labeled_interval_overlap_query.sv @@
// top level: interval and component stores with the query sequencer
// Items are handled one at a time; input ready is high only while idle. A write
// is stored in ST_COMP and its ack is then loaded into the output register in
// ST_ACK, so ready returns once the ack is loaded; ST_ACK waits while an earlier
// result still occupies the output register. A query passes a decode state, then
// per component a slot read and a setup state, then per entry read an address
// state and a registered read data state. A short component reads each entry
// once. A long one reads its last entry, then its first, then bisects (about
// log2(length) reads), then up to two final reads; the backward walk starts from
// the found entry without a new read and reads one entry per step while the
// running max end exceeds the query start. Each hit passes ST_EMIT, which stalls
// while the previous hit waits on the output; the newest hit is held back so the
// final one can carry last, and ST_DONE loads it (or the empty answer). At most
// MAX_HITS (64 by default) hits return; a further hit sets truncated and stops.
// Entry and component stores have no reset; label counts reset to zero.
module labeled_interval_overlap_query #(
	parameter int unsigned ENTRIES = liq_pkg::EntriesDefault,
	parameter int unsigned LABELS = liq_pkg::LabelsDefault,
	parameter int unsigned MAX_COMPONENTS = liq_pkg::MaxCompDefault,
	parameter int unsigned LINEAR_LIMIT = liq_pkg::LinearLimitDefault,
	parameter int unsigned MAX_HITS = liq_pkg::MaxHitsDefault
) (
	input logic clk,
	input logic arst_n,
	liq_if.sink   in_ch,
	liq_if.source out_ch,
	liq_if.sink   cfg
);
	import liq_pkg::*;

	localparam int EW = $clog2(ENTRIES);
	localparam int LW = (LABELS > 1) ? $clog2(LABELS) : 1;
	localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int SW = LW + CW;
	localparam int SLOTS = 1 << SW;
	localparam int NW = $clog2(MAX_COMPONENTS + 1);
	localparam int HW = $clog2(MAX_HITS + 1);
	localparam int PW = EW + 2;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_COMP  = 9'b000000010,
		ST_CREAD = 9'b000000100,
		ST_SETUP = 9'b000001000,
		ST_READ  = 9'b000010000,
		ST_EVAL  = 9'b000100000,
		ST_EMIT  = 9'b001000000,
		ST_ACK   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	typedef enum logic [2:0] {
		PH_LIN   = 3'd0,
		PH_LAST  = 3'd1,
		PH_FIRST = 3'd2,
		PH_MID   = 3'd3,
		PH_FINR  = 3'd4,
		PH_FINL  = 3'd5,
		PH_WALK  = 3'd6
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	in_item_t      in_q;
	logic [NW-1:0] cnt_q [LABELS];
	logic [NW-1:0] ncomp_q, k_q;
	logic [PW-1:0] cs_q, ce_q, l_q, r_q, t_q;
	logic [HW-1:0] hits_q;
	logic          ovf_q;
	out_item_t     pend_q;
	logic          pend_v_q;
	out_item_t     out_q;
	logic          out_v_q;

	// configuration registers
	logic        flt_en_q;
	logic [31:0] min_len_q, max_len_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flt_en_q <= 1'b0;
			min_len_q <= '0;
			max_len_q <= '1;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.data.index))
				REG_FILTER_ENABLE: flt_en_q <= cfg.data.data[0];
				REG_MIN_LENGTH: min_len_q <= cfg.data.data;
				REG_MAX_LENGTH: max_len_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	// entry memory, one wide word per entry
	logic [127:0] ent_mem [ENTRIES];
	logic [127:0] ent_rd;
	logic [EW-1:0] ent_ra;
	logic          ent_we;
	logic [EW-1:0] ent_wa;
	logic [127:0]  ent_wd;
	always_ff @(posedge clk) begin
		if (ent_we) ent_mem[ent_wa] <= ent_wd;
		ent_rd <= ent_mem[ent_ra];
	end
	wire [31:0] r_start = ent_rd[127:96];
	wire [31:0] r_end   = ent_rd[95:64];
	wire [31:0] r_mend  = ent_rd[63:32];
	wire [31:0] r_id    = ent_rd[31:0];

	// component memory
	logic [24:0] cmp_mem [SLOTS];
	logic [24:0] cmp_rd;
	logic [SW-1:0] cmp_ra;
	logic          cmp_we;
	logic [SW-1:0] cmp_wa;
	always_ff @(posedge clk) begin
		if (cmp_we) cmp_mem[cmp_wa] <= {in_q.comp_first, in_q.comp_len};
		cmp_rd <= cmp_mem[cmp_ra];
	end

	wire in_lbl_ok = 32'(in_q.label) < LABELS;
	wire [LW-1:0] lbl = in_q.label[LW-1:0];
	wire [31:0] qs = in_q.start_pos;
	wire [31:0] qe = in_q.end_pos;

	// component range clipped at the table size
	wire [PW-1:0] c_first = PW'(cmp_rd[24:13]);
	wire [PW:0]   c_sum = (PW+1)'(cmp_rd[24:13]) + (PW+1)'(cmp_rd[12:0]);
	wire [PW-1:0] c_end = (c_sum > (PW+1)'(ENTRIES)) ? PW'(ENTRIES) : PW'(c_sum);

	// hit qualification for the entry just read
	wire [31:0] hlen = r_end - r_start;
	wire flt_ok = !flt_en_q || (hlen >= min_len_q && hlen < max_len_q);
	wire lin_done = (t_q + PW'(1)) >= ce_q;
	wire walk_done = (t_q == cs_q);
	wire out_free = !out_v_q || out_ch.ready;

	// bisection bounds after the probe just read
	logic [PW-1:0] nl, nr, mid;
	always_comb begin
		nl = l_q;
		nr = r_q;
		if (phase_q == PH_MID) begin
			if (r_start >= qe) nr = t_q - PW'(1);
			else nl = t_q;
		end
		mid = nl + ((nr - nl) >> 1);
	end

	always_comb begin
		ent_ra = t_q[EW-1:0];
		ent_we = (state_q == ST_COMP) && (kind_t'(in_q.kind) == KIND_ENTRY) &&
			(32'(in_q.addr) < ENTRIES);
		ent_wa = in_q.addr[EW-1:0];
		ent_wd = {in_q.start_pos, in_q.end_pos, in_q.max_end, in_q.item_id};
		cmp_ra = {lbl, k_q[CW-1:0]};
		cmp_we = (state_q == ST_COMP) && (kind_t'(in_q.kind) == KIND_COMP) &&
			(32'(in_q.addr) < MAX_COMPONENTS) && in_lbl_ok;
		cmp_wa = {lbl, in_q.addr[CW-1:0]};
	end

	// next output transfer
	logic      out_load;
	out_item_t out_next;
	out_item_t hit_item;
	always_comb begin
		hit_item = '{query_tag: in_q.item_id, hit_id: r_id, hit_start: r_start,
			hit_end: r_end, hit_valid: 1'b1, truncated: 1'b0, last: 1'b0};
		out_load = 1'b0;
		out_next = pend_q;
		case (state_q)
			ST_ACK: begin
				out_load = out_free;
				out_next = '0;
				out_next.last = 1'b1;
			end
			ST_EMIT: out_load = out_free && pend_v_q && (hits_q < HW'(MAX_HITS));
			ST_DONE: begin
				out_load = out_free;
				if (pend_v_q) begin
					out_next.last = 1'b1;
					out_next.truncated = ovf_q;
				end else begin
					out_next = '0;
					out_next.query_tag = in_q.item_id;
					out_next.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q <= '0;
		end else if (out_load) begin
			out_q <= out_next;
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_LIN;
			hits_q <= '0;
			ovf_q <= 1'b0;
			k_q <= '0;
			ncomp_q <= '0;
			cs_q <= '0;
			ce_q <= '0;
			l_q <= '0;
			r_q <= '0;
			t_q <= '0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < LABELS; i++) cnt_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					in_q <= in_ch.data;
					hits_q <= '0;
					ovf_q <= 1'b0;
					k_q <= '0;
					pend_v_q <= 1'b0;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					if (cmp_we) cnt_q[lbl] <= (32'(in_q.comp_count) > MAX_COMPONENTS) ?
						NW'(MAX_COMPONENTS) : NW'(in_q.comp_count);
					if (kind_t'(in_q.kind) == KIND_QUERY) begin
						ncomp_q <= in_lbl_ok ? cnt_q[lbl] : '0;
						state_q <= ST_CREAD;
					end else state_q <= ST_ACK;
				end
				ST_CREAD: begin
					if (k_q >= ncomp_q) state_q <= ST_DONE;
					else state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					k_q <= k_q + NW'(1);
					if (c_first >= PW'(ENTRIES) || c_end <= c_first) state_q <= ST_CREAD;
					else begin
						cs_q <= c_first;
						ce_q <= c_end;
						if (c_end - c_first > PW'(LINEAR_LIMIT)) begin
							phase_q <= PH_LAST;
							l_q <= c_first;
							r_q <= c_end - PW'(1);
							t_q <= c_end - PW'(1);
						end else begin
							phase_q <= PH_LIN;
							t_q <= c_first;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: begin
					case (phase_q)
						PH_LIN: begin
							if (r_start < qe && r_end > qs && flt_ok) state_q <= ST_EMIT;
							else if (lin_done) state_q <= ST_CREAD;
							else begin
								t_q <= t_q + PW'(1);
								state_q <= ST_READ;
							end
						end
						// last entry of the component: walk from it if it starts below the query end
						PH_LAST: begin
							if (r_start < qe) phase_q <= PH_WALK;
							else begin
								t_q <= l_q;
								phase_q <= PH_FIRST;
								state_q <= ST_READ;
							end
						end
						// first entry not below the query end: nothing to walk; else bisect
						PH_FIRST: begin
							if (r_start >= qe) state_q <= ST_CREAD;
							else if (l_q + PW'(1) < r_q) begin
								t_q <= mid;
								phase_q <= PH_MID;
								state_q <= ST_READ;
							end else begin
								t_q <= r_q;
								phase_q <= PH_FINR;
								state_q <= ST_READ;
							end
						end
						// bisection step
						PH_MID: begin
							l_q <= nl;
							r_q <= nr;
							if (nl + PW'(1) < nr) t_q <= mid;
							else begin
								t_q <= nr;
								phase_q <= PH_FINR;
							end
							state_q <= ST_READ;
						end
						PH_FINR: begin
							if (r_start < qe) phase_q <= PH_WALK;
							else begin
								t_q <= l_q;
								phase_q <= PH_FINL;
								state_q <= ST_READ;
							end
						end
						PH_FINL: begin
							if (r_start < qe) phase_q <= PH_WALK;
							else state_q <= ST_CREAD;
						end
						// backward walk while the running max end reaches the query
						PH_WALK: begin
							if (r_mend > qs) begin
								if (r_end > qs && flt_ok) state_q <= ST_EMIT;
								else if (walk_done) state_q <= ST_CREAD;
								else begin
									t_q <= t_q - PW'(1);
									state_q <= ST_READ;
								end
							end else state_q <= ST_CREAD;
						end
						default: state_q <= ST_CREAD;
					endcase
				end
				// the held hit moves to the output, the new one is held; past the hit limit the query ends
				ST_EMIT: begin
					if (hits_q >= HW'(MAX_HITS)) begin
						ovf_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (!pend_v_q || out_free) begin
						pend_q <= hit_item;
						pend_v_q <= 1'b1;
						hits_q <= hits_q + HW'(1);
						if (phase_q == PH_LIN) begin
							if (lin_done) state_q <= ST_CREAD;
							else begin
								t_q <= t_q + PW'(1);
								state_q <= ST_READ;
							end
						end else begin
							if (walk_done) state_q <= ST_CREAD;
							else begin
								t_q <= t_q - PW'(1);
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_ACK: if (out_free) state_q <= ST_IDLE;
				ST_DONE: if (out_free) begin
					pend_v_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= HW'(MAX_HITS)) else $error("hit count overrun");
	a_busy_noaccept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_ACK && state_q == ST_IDLE |-> out_q.last)
		else $error("ack without last");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while waiting");
endmodule
